// ----- hdl/rcw_pkg.sv -----
package rcw_pkg;

    localparam int ALPHA       = 26;
    localparam int WHEEL_COUNT = 5;

    localparam logic [7:0] CHAR_A = 8'h41;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] wheel_t;
    typedef logic [ALPHA-1:0][4:0] wiring_t;
    typedef wiring_t [WHEEL_COUNT-1:0] wheel_set_t;

    typedef enum logic [1:0]
    {
        CMD_FORWARD = 2'd0,
        CMD_REVERSE = 2'd1,
        CMD_STEP    = 2'd2,
        CMD_RESTART = 2'd3
    } command_t;

    localparam logic [1:0] REG_WHEEL_CHOICE   = 2'd0;
    localparam logic [1:0] REG_RING_SETTING   = 2'd1;
    localparam logic [1:0] REG_START_POSITION = 2'd2;

    localparam wheel_t LAST_WHEEL = wheel_t'(WHEEL_COUNT - 1);

    localparam logic [8*ALPHA-1:0] WIRING_TEXT [WHEEL_COUNT] = '{
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "VZBRGITYUPSDNHLXAWMJQOFECK"
    };

    // Turnover letters R, F, W, K and A, wheel 0 in the lowest slot.
    localparam letter_t [WHEEL_COUNT-1:0] TURNOVER = {5'd0, 5'd10, 5'd22, 5'd5, 5'd17};

    function automatic wheel_set_t build_fwd();
        wheel_set_t t;
        t = '0;
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            for (int i = 0; i < ALPHA; i++)
            begin
                t[w][i] = letter_t'(WIRING_TEXT[w][8*(ALPHA-1-i) +: 8] - CHAR_A);
            end
        end
        return t;
    endfunction

    function automatic wheel_set_t build_rev();
        wheel_set_t f;
        wheel_set_t t;
        f = build_fwd();
        t = '0;
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            for (int i = 0; i < ALPHA; i++)
            begin
                t[w][f[w][i]] = letter_t'(i);
            end
        end
        return t;
    endfunction

    localparam wheel_set_t WIRE_FWD = build_fwd();
    localparam wheel_set_t WIRE_REV = build_rev();

    // Folds a value below twice the alphabet size into 0..25.
    function automatic letter_t reduce_mod(input logic [5:0] v);
        logic [5:0] r;
        r = (v >= 6'(ALPHA)) ? v - 6'(ALPHA) : v;
        return r[4:0];
    endfunction

    function automatic letter_t add_mod(input letter_t a, input letter_t b);
        return reduce_mod({1'b0, a} + {1'b0, b});
    endfunction

    function automatic letter_t sub_mod(input letter_t a, input letter_t b);
        logic [5:0] r;
        r = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + 6'(ALPHA) - {1'b0, b};
        return r[4:0];
    endfunction

endpackage

// ----- hdl/rotor_cipher_wheel.sv -----
// One cipher rotor with the five standard wirings I to V and their turnover letters.
// Input beats arrive on the s_axis channel: tuser carries the command (forward map,
// reverse map, step, restart) and tdata the contact letter. Each input beat gives
// exactly one output beat on m_axis: the mapped letter (zero on step and restart),
// the turnover flag from the position before the beat, and the position after it.
// The configuration channel writes wheel choice, ring setting and start position; it
// is always ready and should be used only while no beat is in flight.
// An accepted beat is a valid output beat in the next cycle, and one beat per cycle
// is sustained unless stalled. The mapping is a table lookup between two mod-26
// offsets before the output register, and the rotor position updates at acceptance.
// While the receiver stalls, the output beat is held and s_axis_tready falls only when
// the output register is full and not being taken, so nothing is lost.
// Reset clears the position, all three configuration registers and the output valid.
module rotor_cipher_wheel
    import rcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [4:0] letter_in, [7:5] zero
    input  logic [1:0] s_axis_tuser,   // [1:0] command

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [4:0] letter_out, [5] at_turnover,
                                       // [10:6] position_now, [15:11] zero
);

    wheel_t  wheel_reg;
    letter_t ring_reg;
    letter_t start_reg;
    letter_t position_reg;
    letter_t position_next;

    logic    out_valid_reg;
    letter_t out_letter_reg;
    letter_t out_letter_next;
    logic    out_turn_reg;
    logic    out_turn_next;
    letter_t out_position_reg;

    logic     accept;
    command_t command;
    letter_t  letter;
    letter_t  contact;
    letter_t  wired;
    letter_t  mapped;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        command  = command_t'(s_axis_tuser);
        letter   = reduce_mod({1'b0, s_axis_tdata[4:0]});
        contact  = sub_mod(add_mod(position_reg, letter), ring_reg);
        wired    = (command == CMD_REVERSE) ? WIRE_REV[wheel_reg][contact]
                                            : WIRE_FWD[wheel_reg][contact];
        mapped   = add_mod(wired, ring_reg);
        out_turn_next = (position_reg == TURNOVER[wheel_reg]);

        case (command)
            CMD_FORWARD, CMD_REVERSE:
            begin
                out_letter_next = sub_mod(mapped, position_reg);
                position_next   = position_reg;
            end
            CMD_STEP:
            begin
                out_letter_next = '0;
                position_next   = add_mod(position_reg, letter_t'(1));
            end
            default:
            begin
                out_letter_next = '0;
                position_next   = start_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_reg     <= '0;
            ring_reg      <= '0;
            start_reg     <= '0;
            position_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WHEEL_CHOICE:
                    begin
                        wheel_reg <= (cfg_data[2:0] > LAST_WHEEL) ? LAST_WHEEL : cfg_data[2:0];
                    end
                    REG_RING_SETTING:
                    begin
                        ring_reg <= reduce_mod({1'b0, cfg_data});
                    end
                    REG_START_POSITION:
                    begin
                        start_reg <= reduce_mod({1'b0, cfg_data});
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                position_reg <= position_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_letter_reg   <= out_letter_next;
            out_turn_reg     <= out_turn_next;
            out_position_reg <= position_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_position_reg, out_turn_reg, out_letter_reg};

endmodule

// ----- hdl/rcw_checker.sv -----
module rcw_checker
    import rcw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A stalled output beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // Every accepted input beat shows up as an output beat in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat did not reach the output");

    // Step and restart beats carry no letter.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
            && (s_axis_tuser == CMD_STEP || s_axis_tuser == CMD_RESTART)
            |=> m_axis_tdata[4:0] == 5'd0)
        else $error("step or restart beat carries a letter");

    // Letter and position of a valid output beat always stay inside the alphabet.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:0] < 5'(ALPHA)) && (m_axis_tdata[10:6] < 5'(ALPHA)))
        else $error("output letter or position out of range");

endmodule

bind rotor_cipher_wheel rcw_checker u_rcw_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_rotor_cipher_wheel.sv -----
`timescale 1ns / 1ps

module tb_rotor_cipher_wheel;

    import rcw_pkg::*;

    localparam int         LONG_HOLD   = 48;
    localparam int         PHASE_BEATS = 125;
    localparam int         PHASES      = 8;
    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam logic [7:0] LETTER_A    = 8'h41;

    typedef struct packed
    {
        letter_t position_now;
        logic    at_turnover;
        letter_t letter_out;
    } rotor_result_t;

    typedef enum logic
    {
        ROW_BEAT,
        ROW_REG
    } row_kind_t;

    typedef struct
    {
        row_kind_t     kind;
        command_t      cmd;
        logic [4:0]    letter;
        logic [1:0]    reg_idx;
        logic [4:0]    reg_val;
        logic          known;
        rotor_result_t res;
    } plan_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = '0;
    logic [4:0]  cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    logic          beat_known     = 1'b0;
    rotor_result_t beat_known_res = '0;

    logic [8*ALPHA-1:0] wheel_wiring [WHEEL_COUNT] = '{
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "VZBRGITYUPSDNHLXAWMJQOFECK"
    };
    int turnover_letter [WHEEL_COUNT] = '{17, 5, 22, 10, 0};

    logic [2:0] wheel_sel = '0;
    logic [4:0] ring_sel  = '0;
    logic [4:0] start_sel = '0;
    letter_t    rotor_pos = '0;

    rotor_result_t pending_results [$];
    rotor_result_t predicted_res;
    rotor_result_t expected_res;
    plan_row_t     plan [$];

    bit idle_en       = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int fail_count    = 0;
    int beats_in      = 0;
    int beats_out     = 0;
    int reg_writes    = 0;
    int cmd_seen [4]  = '{0, 0, 0, 0};

    rotor_cipher_wheel u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int wire_lookup(int w, int idx);
        return int'(wheel_wiring[w][8*(ALPHA-1-idx) +: 8]) - int'(LETTER_A);
    endfunction

    function automatic int wire_inverse(int w, int letter);
        for (int i = 0; i < ALPHA; i++)
        begin
            if (wire_lookup(w, i) == letter)
                return i;
        end
        return 0;
    endfunction

    function automatic rotor_result_t rotor_predict(command_t cmd, logic [4:0] letter_raw);
        int            w;
        int            ring;
        int            pos;
        int            letter;
        int            contact;
        int            mapped;
        rotor_result_t r;
        w      = (int'(wheel_sel) >= WHEEL_COUNT) ? WHEEL_COUNT - 1 : int'(wheel_sel);
        ring   = int'(ring_sel) % ALPHA;
        pos    = int'(rotor_pos) % ALPHA;
        letter = int'(letter_raw) % ALPHA;
        r.letter_out  = '0;
        r.at_turnover = (pos == turnover_letter[w]);
        case (cmd)
            CMD_FORWARD, CMD_REVERSE:
            begin
                contact = (pos + letter + ALPHA - ring) % ALPHA;
                mapped  = (cmd == CMD_FORWARD) ? wire_lookup(w, contact)
                                               : wire_inverse(w, contact);
                mapped  = (mapped + ring) % ALPHA;
                r.letter_out = letter_t'((mapped + ALPHA - pos) % ALPHA);
            end
            CMD_STEP:
                pos = (pos + 1) % ALPHA;
            default:
                pos = int'(start_sel) % ALPHA;
        endcase
        rotor_pos      = letter_t'(pos);
        r.position_now = letter_t'(pos);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                beats_out++;
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing pending: tdata=%h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    expected_res = pending_results.pop_front();
                    if (m_axis_tdata[4:0] !== expected_res.letter_out)
                    begin
                        $error("letter_out: expected %0d, actual %0d",
                               expected_res.letter_out, m_axis_tdata[4:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[5] !== expected_res.at_turnover)
                    begin
                        $error("at_turnover: expected %0d, actual %0d",
                               expected_res.at_turnover, m_axis_tdata[5]);
                        fail_count++;
                    end
                    if (m_axis_tdata[10:6] !== expected_res.position_now)
                    begin
                        $error("position_now: expected %0d, actual %0d",
                               expected_res.position_now, m_axis_tdata[10:6]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                beats_in++;
                cmd_seen[s_axis_tuser]++;
                predicted_res = rotor_predict(command_t'(s_axis_tuser), s_axis_tdata[4:0]);
                pending_results.push_back(beat_known ? beat_known_res : predicted_res);
            end
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                case (cfg_index)
                    REG_WHEEL_CHOICE:   wheel_sel = cfg_data[2:0];
                    REG_RING_SETTING:   ring_sel  = cfg_data;
                    REG_START_POSITION: start_sel = cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic plan_open(command_t cmd, logic [4:0] letter);
        plan_row_t row;
        row = '{kind: ROW_BEAT, cmd: cmd, letter: letter, reg_idx: '0, reg_val: '0,
                known: 1'b0, res: '0};
        plan.push_back(row);
    endtask

    task automatic plan_known(command_t cmd, logic [4:0] letter,
                              letter_t lo, logic tu, letter_t po);
        plan_row_t row;
        row = '{kind: ROW_BEAT, cmd: cmd, letter: letter, reg_idx: '0, reg_val: '0,
                known: 1'b1, res: '{position_now: po, at_turnover: tu, letter_out: lo}};
        plan.push_back(row);
    endtask

    task automatic plan_reg(logic [1:0] idx, logic [4:0] val);
        plan_row_t row;
        row = '{kind: ROW_REG, cmd: CMD_FORWARD, letter: '0, reg_idx: idx, reg_val: val,
                known: 1'b0, res: '0};
        plan.push_back(row);
    endtask

    task automatic send_beat(command_t cmd, logic [4:0] letter,
                             logic known, rotor_result_t res);
        s_axis_tvalid  <= 1'b1;
        s_axis_tuser   <= cmd;
        s_axis_tdata   <= {3'b000, letter};
        beat_known     <= known;
        beat_known_res <= res;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic sender_gap();
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        command_t   cmd;
        int         pick;
        logic [2:0] w_val;
        logic [4:0] r_val;
        logic [4:0] s_val;

        // After reset: wheel I, ring A, position A.
        plan_known(CMD_FORWARD, 5'd0,  5'd4,  1'b0, 5'd0);
        plan_known(CMD_FORWARD, 5'd25, 5'd9,  1'b0, 5'd0);
        plan_known(CMD_REVERSE, 5'd0,  5'd20, 1'b0, 5'd0);
        plan_known(CMD_FORWARD, 5'd26, 5'd4,  1'b0, 5'd0);
        plan_known(CMD_FORWARD, 5'd31, 5'd6,  1'b0, 5'd0);
        plan_known(CMD_STEP,    5'd0,  5'd0,  1'b0, 5'd1);
        plan_known(CMD_RESTART, 5'd31, 5'd0,  1'b0, 5'd0);
        plan_open(CMD_REVERSE, 5'd31);
        // Wheel V turns over at A, so the restart beat, taken at position A, reports it.
        plan_reg(REG_WHEEL_CHOICE, 5'd4);
        plan_reg(REG_RING_SETTING, 5'd25);
        plan_reg(REG_START_POSITION, 5'd25);
        plan_known(CMD_RESTART, 5'd0, 5'd0, 1'b1, 5'd25);
        plan_known(CMD_STEP,    5'd0, 5'd0, 1'b0, 5'd0);
        plan_open(CMD_FORWARD, 5'd0);
        plan_open(CMD_REVERSE, 5'd25);
        plan_open(CMD_FORWARD, 5'd13);
        plan_open(CMD_REVERSE, 5'd7);
        // Out-of-range wheel saturates, ring and start fold modulo 26.
        plan_reg(REG_WHEEL_CHOICE, 5'd7);
        plan_reg(REG_RING_SETTING, 5'd31);
        plan_reg(REG_START_POSITION, 5'd30);
        plan_reg(REG_SPARE, 5'd31);
        plan_known(CMD_RESTART, 5'd5, 5'd0, 1'b1, 5'd4);
        plan_open(CMD_FORWARD, 5'd0);
        plan_open(CMD_REVERSE, 5'd0);
        plan_open(CMD_STEP, 5'd17);
        plan_open(CMD_FORWARD, 5'd31);
        plan_open(CMD_REVERSE, 5'd26);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                drain_results();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                send_beat(plan[i].cmd, plan[i].letter, plan[i].known, plan[i].res);
                sender_gap();
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin w_val = 3'd0; r_val = 5'd0;  s_val = 5'd0;  end
                1:       begin w_val = 3'd4; r_val = 5'd25; s_val = 5'd25; end
                2:       begin w_val = 3'd7; r_val = 5'd31; s_val = 5'd26; end
                default:
                begin
                    w_val = 3'($urandom_range(0, 7));
                    r_val = 5'($urandom_range(0, 31));
                    s_val = 5'($urandom_range(0, 31));
                end
            endcase
            drain_results();
            write_reg(REG_WHEEL_CHOICE, {2'b00, w_val});
            write_reg(REG_RING_SETTING, r_val);
            write_reg(REG_START_POSITION, s_val);
            idle_en = (phase < PHASES - 1);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    cmd = CMD_FORWARD;
                else if (pick < 7)
                    cmd = CMD_REVERSE;
                else if (pick < 9)
                    cmd = CMD_STEP;
                else
                    cmd = CMD_RESTART;
                if (phase == 3 && n == 20)
                    hold_requests++;
                if (phase == 5 && n == 60)
                    drain_results();
                send_beat(cmd, 5'($urandom_range(0, 31)), 1'b0, '0);
                sender_gap();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected result beats never arrived", pending_results.size());
            fail_count++;
        end
        $display("Drove %0d beats (forward %0d, reverse %0d, step %0d, restart %0d).",
                 beats_in, cmd_seen[CMD_FORWARD], cmd_seen[CMD_REVERSE],
                 cmd_seen[CMD_STEP], cmd_seen[CMD_RESTART]);
        $display("Made %0d register writes, compared %0d result beats, found %0d problems.",
                 reg_writes, beats_out, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
